// File: sv/cffsa_pkg.sv
`timescale 1ns / 1ps

package cffsa_pkg;

	// Fixed field widths.
	localparam int SLOT_W = 9;
	localparam int CFG_W  = 9;

	// Occupancy words: one bit per slot, slot number = row * WORD_W + bit.
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_READ,
		ST_CHECK,
		ST_GRANT,
		ST_FULL,
		ST_FREE
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic next_row;
		logic wrap;
		logic commit_alloc;
		logic commit_rel;
		logic load_full;
	} cmd_t;

	typedef struct packed {
		logic range_empty;
		logic hit;
		logic last_row;
		logic phase_a;
		logic is_rel;
		logic out_free;
	} stat_t;

endpackage

// File: sv/cffsa_ctrl.sv
`timescale 1ns / 1ps

module cffsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cffsa_pkg::stat_t st,
	output cffsa_pkg::cmd_t  cmd
);

	cffsa_pkg::state_t state_q;
	cffsa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cffsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			cffsa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = cffsa_pkg::ST_START;
				end
			end
			cffsa_pkg::ST_START: begin
				if (!st.range_empty) begin
					state_d = cffsa_pkg::ST_READ;
				end else if (st.is_rel) begin
					state_d = cffsa_pkg::ST_IDLE;
				end else if (st.phase_a) begin
					cmd.wrap = 1'b1;
				end else begin
					state_d = cffsa_pkg::ST_FULL;
				end
			end
			cffsa_pkg::ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = cffsa_pkg::ST_CHECK;
			end
			cffsa_pkg::ST_CHECK: begin
				if (st.is_rel) begin
					state_d = cffsa_pkg::ST_FREE;
				end else if (st.hit) begin
					state_d = cffsa_pkg::ST_GRANT;
				end else if (!st.last_row) begin
					cmd.next_row = 1'b1;
					state_d      = cffsa_pkg::ST_READ;
				end else if (st.phase_a) begin
					// Nothing free from the preferred slot up; search from slot 1.
					cmd.wrap = 1'b1;
					state_d  = cffsa_pkg::ST_START;
				end else begin
					state_d = cffsa_pkg::ST_FULL;
				end
			end
			cffsa_pkg::ST_GRANT: begin
				if (st.out_free) begin
					cmd.commit_alloc = 1'b1;
					state_d          = cffsa_pkg::ST_IDLE;
				end
			end
			cffsa_pkg::ST_FULL: begin
				if (st.out_free) begin
					cmd.load_full = 1'b1;
					state_d       = cffsa_pkg::ST_IDLE;
				end
			end
			cffsa_pkg::ST_FREE: begin
				cmd.commit_rel = 1'b1;
				state_d        = cffsa_pkg::ST_IDLE;
			end
			default: begin
				state_d = cffsa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: sv/cffsa_dp.sv
`timescale 1ns / 1ps

module cffsa_dp #(
	parameter int SLOTS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cffsa_pkg::CFG_W-1:0]    cfg_data,
	input  logic                           op,
	input  logic [cffsa_pkg::SLOT_W-1:0]   slot,
	input  cffsa_pkg::cmd_t                cmd,
	output cffsa_pkg::stat_t               st,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cffsa_pkg::SLOT_W-1:0]   granted_slot,
	output logic                           full_res
);

	// Slot numbers above what the slot field can name are never reached.
	localparam int SLOT_MAX = (1 << cffsa_pkg::SLOT_W) - 1;
	localparam int MAX_SLOT = (SLOTS < SLOT_MAX) ? SLOTS : SLOT_MAX;
	localparam int ROWS     = MAX_SLOT / cffsa_pkg::WORD_W + 1;
	localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [cffsa_pkg::SLOT_W-1:0] NMAX = cffsa_pkg::SLOT_W'(MAX_SLOT);
	localparam logic [cffsa_pkg::SLOT_W-1:0] ONE  = cffsa_pkg::SLOT_W'(1);

	function automatic logic [ROW_W-1:0] row_of(input logic [cffsa_pkg::SLOT_W-1:0] s);
		return ROW_W'(s >> cffsa_pkg::BIT_W);
	endfunction

	logic [cffsa_pkg::CFG_W-1:0]  cfg_q;
	logic [cffsa_pkg::WORD_W-1:0] mem [ROWS];
	logic [ROWS-1:0]              rvalid_q;
	logic [cffsa_pkg::WORD_W-1:0] rdata_q;
	logic [cffsa_pkg::SLOT_W-1:0] lo_q;
	logic [cffsa_pkg::SLOT_W-1:0] hi_q;
	logic [cffsa_pkg::SLOT_W-1:0] wrap_hi_q;
	logic [ROW_W-1:0]             row_q;
	logic                         phase_a_q;
	logic                         is_rel_q;
	logic                         out_valid_q;
	logic [cffsa_pkg::SLOT_W-1:0] granted_q;
	logic                         full_q;

	logic [cffsa_pkg::SLOT_W-1:0] n;
	logic [cffsa_pkg::SLOT_W-1:0] start;
	logic [cffsa_pkg::WORD_W-1:0] lo_mask;
	logic [cffsa_pkg::WORD_W-1:0] hi_mask;
	logic [cffsa_pkg::WORD_W-1:0] free_bits;
	logic [cffsa_pkg::BIT_W-1:0]  fidx;
	logic [cffsa_pkg::SLOT_W-1:0] found_slot;
	logic [cffsa_pkg::WORD_W-1:0] bit_sel;
	logic                         out_free;

	assign n     = (cfg_q > NMAX) ? NMAX : cfg_q;
	assign start = (slot == '0) ? ONE : slot;

	// Keep only the bits of the current row that lie inside lo..hi.
	assign lo_mask = (row_q == row_of(lo_q)) ?
		({cffsa_pkg::WORD_W{1'b1}} << lo_q[cffsa_pkg::BIT_W-1:0]) : '1;
	assign hi_mask = (row_q == row_of(hi_q)) ?
		({cffsa_pkg::WORD_W{1'b1}} >> (cffsa_pkg::BIT_W'(cffsa_pkg::WORD_W - 1)
			- hi_q[cffsa_pkg::BIT_W-1:0])) : '1;
	assign free_bits = ~rdata_q & lo_mask & hi_mask;

	always_comb begin
		fidx = '0;
		for (int j = cffsa_pkg::WORD_W - 1; j >= 0; j--) begin
			if (free_bits[j]) begin
				fidx = cffsa_pkg::BIT_W'(j);
			end
		end
	end

	assign found_slot = (cffsa_pkg::SLOT_W'(row_q) << cffsa_pkg::BIT_W)
		| cffsa_pkg::SLOT_W'(fidx);
	assign bit_sel  = cffsa_pkg::WORD_W'(1) << lo_q[cffsa_pkg::BIT_W-1:0];
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		st.range_empty = lo_q > hi_q;
		st.hit         = |free_bits;
		st.last_row    = row_q == row_of(hi_q);
		st.phase_a     = phase_a_q;
		st.is_rel      = is_rel_q;
		st.out_free    = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= cffsa_pkg::CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_data;
		end
	end

	// Search window and row pointer.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_rel_q  <= op == cffsa_pkg::OP_RELEASE;
			wrap_hi_q <= start - ONE;
			if (op == cffsa_pkg::OP_RELEASE) begin
				phase_a_q <= 1'b0;
				if (slot != '0 && slot <= n) begin
					lo_q  <= slot;
					hi_q  <= slot;
					row_q <= row_of(slot);
				end else begin
					lo_q  <= ONE;
					hi_q  <= '0;
					row_q <= '0;
				end
			end else if (start <= n) begin
				phase_a_q <= 1'b1;
				lo_q      <= start;
				hi_q      <= n;
				row_q     <= row_of(start);
			end else begin
				phase_a_q <= 1'b0;
				lo_q      <= ONE;
				hi_q      <= n;
				row_q     <= '0;
			end
		end else if (cmd.wrap) begin
			phase_a_q <= 1'b0;
			lo_q      <= ONE;
			hi_q      <= wrap_hi_q;
			row_q     <= '0;
		end else if (cmd.next_row) begin
			row_q <= row_q + ROW_W'(1);
		end
	end

	// Occupancy words; a row never written reads as all free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= '0;
		end else if (cmd.commit_alloc || cmd.commit_rel) begin
			rvalid_q[row_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit_alloc) begin
			mem[row_q] <= rdata_q | (cffsa_pkg::WORD_W'(1) << fidx);
		end else if (cmd.commit_rel) begin
			mem[row_q] <= rdata_q & ~bit_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= rvalid_q[row_q] ? mem[row_q] : '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit_alloc || cmd.load_full) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit_alloc) begin
			granted_q <= found_slot;
			full_q    <= 1'b0;
		end else if (cmd.load_full) begin
			granted_q <= '0;
			full_q    <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign granted_slot = granted_q;
	assign full_res     = full_q;

endmodule

// File: sv/circular_first_free_slot_allocator.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Word
// in        input      in_valid / in_ready   op, slot
// out       output     out_valid / out_ready granted_slot, full_res
// cfg       input      cfg_we                cfg_data (slots_in_use)
//
// One request at a time. A release of a managed slot passes through start, read, check and
// free before the next acceptance; an ignored release goes back to idle from start. An allocate
// reads and checks the 32-slot occupancy rows one by one, a read and a check per row, at most
// rows(SLOTS) + 1 rows, and wraps to search from slot 1 when the preferred slot's range came up empty.
// Reset is immediate: every row is marked free by per-row valid flops, no clearing pass.
// A held result stalls a grant or full result, and with it the next accept; releases do not wait.

module circular_first_free_slot_allocator #(
	parameter int SLOTS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cffsa_pkg::CFG_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic [cffsa_pkg::SLOT_W-1:0] slot,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [cffsa_pkg::SLOT_W-1:0] granted_slot,
	output logic                         full_res
);

	cffsa_pkg::cmd_t  cmd;
	cffsa_pkg::stat_t st;

	cffsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	cffsa_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.op           (op),
		.slot         (slot),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.granted_slot (granted_slot),
		.full_res     (full_res)
	);

endmodule

// File: sv/cffsa_chk.sv
`timescale 1ns / 1ps

module cffsa_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [cffsa_pkg::SLOT_W-1:0] granted_slot,
	input logic                         full_res
);

	// A result that is not taken holds its word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(granted_slot) && $stable(full_res))
		else $error("result word changed while stalled");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full_res |-> granted_slot == '0)
		else $error("full result carries a nonzero slot");

	a_grant_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !full_res |-> granted_slot != '0)
		else $error("grant of slot zero");

	// Requests are served one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request accepted while one is in flight");

	a_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("not ready for a new request after a result");

endmodule

bind circular_first_free_slot_allocator cffsa_chk u_cffsa_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.granted_slot (granted_slot),
	.full_res     (full_res)
);

// File: dv/tb_circular_first_free_slot_allocator.sv
`timescale 1ns / 1ps

module tb_circular_first_free_slot_allocator;

	localparam int NUM_SLOTS      = 256;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [cffsa_pkg::SLOT_W-1:0] slot;
		logic                         full;
	} grant_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [cffsa_pkg::CFG_W-1:0]  cfg_data;
	logic                         in_valid;
	logic                         in_ready;
	logic                         op;
	logic [cffsa_pkg::SLOT_W-1:0] slot;
	logic                         out_valid;
	logic                         out_ready;
	logic [cffsa_pkg::SLOT_W-1:0] granted_slot;
	logic                         full_res;

	// Shadow copy of the allocator state.
	bit                          occ_map [1:NUM_SLOTS];
	logic [cffsa_pkg::CFG_W-1:0] slot_limit;
	grant_t                      pending_grants[$];

	int err_count = 0;
	int idle_cycles = 0;
	bit burst_mode;

	circular_first_free_slot_allocator #(
		.SLOTS(NUM_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.slot(slot),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.granted_slot(granted_slot),
		.full_res(full_res)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int managed_count();
		return (slot_limit > NUM_SLOTS) ? NUM_SLOTS : int'(slot_limit);
	endfunction

	function automatic grant_t predict_allocate(input logic [cffsa_pkg::SLOT_W-1:0] pref);
		grant_t r;
		int     n;
		int     start;
		int     hi;
		r.slot = '0;
		r.full = 1'b1;
		n = managed_count();
		if (n > 0) begin
			start = (pref == 0) ? 1 : int'(pref);
			for (int s = start; s <= n && r.full; s++) begin
				if (!occ_map[s]) begin
					r.slot = cffsa_pkg::SLOT_W'(s);
					r.full = 1'b0;
				end
			end
			// Wrap: search from slot 1 up to just before the preferred slot.
			hi = (start - 1 > n) ? n : start - 1;
			for (int s = 1; s <= hi && r.full; s++) begin
				if (!occ_map[s]) begin
					r.slot = cffsa_pkg::SLOT_W'(s);
					r.full = 1'b0;
				end
			end
		end
		if (!r.full)
			occ_map[r.slot] = 1'b1;
		return r;
	endfunction

	function automatic void predict_release(input logic [cffsa_pkg::SLOT_W-1:0] s);
		if (s >= 1 && s <= managed_count())
			occ_map[s] = 1'b0;
	endfunction

	function automatic logic [cffsa_pkg::SLOT_W-1:0] pick_taken_slot();
		int n;
		int start;
		int s;
		n = managed_count();
		if (n > 0) begin
			start = $urandom_range(1, n);
			for (int k = 0; k < n; k++) begin
				s = (start - 1 + k) % n + 1;
				if (occ_map[s])
					return cffsa_pkg::SLOT_W'(s);
			end
		end
		return cffsa_pkg::SLOT_W'($urandom_range(0, 511));
	endfunction

	// Entered and left at a falling edge; valid is left high for the next word.
	task automatic send_word(input logic op_v, input logic [cffsa_pkg::SLOT_W-1:0] slot_v);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= op_v;
		slot     <= slot_v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (op_v == cffsa_pkg::OP_ALLOC)
			pending_grants.push_back(predict_allocate(slot_v));
		else
			predict_release(slot_v);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(negedge clk);
		// A release gives no word back, so allow its processing to finish.
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_slot_count(input logic [cffsa_pkg::CFG_W-1:0] value);
		settle();
		cfg_we     <= 1'b1;
		cfg_data   <= value;
		slot_limit = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_edge_slots();
		send_word(cffsa_pkg::OP_ALLOC, 9'd0);
		send_word(cffsa_pkg::OP_ALLOC, 9'd256);
		send_word(cffsa_pkg::OP_ALLOC, 9'd511);
		send_word(cffsa_pkg::OP_ALLOC, 9'd255);
		send_word(cffsa_pkg::OP_RELEASE, 9'd0);
		send_word(cffsa_pkg::OP_RELEASE, 9'd300);
		send_word(cffsa_pkg::OP_RELEASE, 9'd7);
		send_word(cffsa_pkg::OP_RELEASE, 9'd256);
		send_word(cffsa_pkg::OP_ALLOC, 9'd256);
	endtask

	task automatic test_count_extremes();
		write_slot_count(9'd1);
		send_word(cffsa_pkg::OP_ALLOC, 9'd0);
		send_word(cffsa_pkg::OP_RELEASE, 9'd1);
		send_word(cffsa_pkg::OP_ALLOC, 9'd300);
		send_word(cffsa_pkg::OP_ALLOC, 9'd1);
		write_slot_count(9'd0);
		send_word(cffsa_pkg::OP_ALLOC, 9'd0);
		send_word(cffsa_pkg::OP_RELEASE, 9'd1);
		send_word(cffsa_pkg::OP_ALLOC, 9'd5);
		write_slot_count(9'd511);
		send_word(cffsa_pkg::OP_ALLOC, 9'd0);
	endtask

	task automatic test_random_traffic(input logic [cffsa_pkg::CFG_W-1:0] count_v,
		input int n_words, input int alloc_pct, input bit burst);
		int                           n;
		logic [cffsa_pkg::SLOT_W-1:0] s;
		write_slot_count(count_v);
		burst_mode = burst;
		n = managed_count();
		for (int i = 0; i < n_words; i++) begin
			if ($urandom_range(0, 99) < 8) begin
				// Noise: any op with any slot.
				send_word($urandom_range(0, 1) ? cffsa_pkg::OP_RELEASE : cffsa_pkg::OP_ALLOC,
					cffsa_pkg::SLOT_W'($urandom_range(0, 511)));
			end else if ($urandom_range(0, 99) < alloc_pct) begin
				if ($urandom_range(0, 99) < 80)
					s = cffsa_pkg::SLOT_W'($urandom_range(0, n + 1));
				else
					s = cffsa_pkg::SLOT_W'($urandom_range(0, 511));
				send_word(cffsa_pkg::OP_ALLOC, s);
			end else begin
				if ($urandom_range(0, 99) < 70)
					s = pick_taken_slot();
				else
					s = cffsa_pkg::SLOT_W'($urandom_range(0, 511));
				send_word(cffsa_pkg::OP_RELEASE, s);
			end
		end
		burst_mode = 1'b0;
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		op         = cffsa_pkg::OP_ALLOC;
		slot       = '0;
		burst_mode = 1'b0;
		slot_limit = cffsa_pkg::CFG_RESET;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_edge_slots();
		test_count_extremes();
		test_random_traffic(9'd256, 150, 60, 1'b0);
		test_random_traffic(9'd3, 120, 55, 1'b0);
		test_random_traffic(9'd33, 120, 70, 1'b1);
		// Heavy allocation past the parameter limit drives the map to full.
		test_random_traffic(9'd511, 320, 95, 1'b0);
		test_random_traffic(9'd32, 100, 50, 1'b0);
		test_random_traffic(9'd257, 80, 30, 1'b0);
		test_random_traffic(9'd0, 40, 50, 1'b0);
		test_random_traffic(9'd1, 60, 60, 1'b1);
		test_random_traffic(9'd64, 120, 65, 1'b0);
		test_random_traffic(9'd256, 90, 50, 1'b0);

		settle();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Result side: a fresh stall is drawn for every word.
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = burst_mode ? 0 : $urandom_range(0, 16);
			if (gap == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
				out_ready <= 1'b1;
			end
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		grant_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_grants.size() == 0) begin
				$error("unexpected word: granted_slot %0d full_res %0d", granted_slot, full_res);
				err_count++;
			end else begin
				exp_w = pending_grants.pop_front();
				if (granted_slot !== exp_w.slot) begin
					$error("granted_slot: expected %0d, got %0d", exp_w.slot, granted_slot);
					err_count++;
				end
				if (full_res !== exp_w.full) begin
					$error("full_res: expected %0d, got %0d", exp_w.full, full_res);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

// File: circular_first_free_slot_allocator.f
sv/cffsa_pkg.sv
sv/cffsa_ctrl.sv
sv/cffsa_dp.sv
sv/circular_first_free_slot_allocator.sv
sv/cffsa_chk.sv
dv/tb_circular_first_free_slot_allocator.sv
